### rtl/bfem_pkg.sv
// Package for the bitmap free extent manager: sizes, request and status codes.
// Used by all modules under rtl; depends on nothing.
package bfem_pkg;
  localparam int MAX_BLOCKS_DEF = 65536;
  localparam int WORD_BITS_DEF  = 64;
  localparam int ADDR_BITS      = 48;
  localparam int CNT_BITS       = 17;
  localparam int SHIFT_BITS     = 5;
  localparam logic [4:0] SHIFT_MIN = 5'd9;
  localparam logic [4:0] SHIFT_MAX = 5'd20;
  localparam logic [4:0] SHIFT_RST = 5'd12;

  typedef enum logic [1:0] {
    FN_TOGGLE  = 2'd0,
    FN_RESTART = 2'd1,
    FN_NEXT    = 2'd2,
    FN_VERIFY  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD      = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_FINISHED = 2'd3
  } status_t;

  localparam logic CFG_SHIFT  = 1'b0;
  localparam logic CFG_BLOCKS = 1'b1;
endpackage

### rtl/bfem_bitmap_ram.sv
// Bitmap word store: one write port, one registered read port.
// Depends on bfem_pkg for its default depth and width.
module bfem_bitmap_ram import bfem_pkg::*; #(
  parameter int DEPTH = MAX_BLOCKS_DEF / WORD_BITS_DEF,
  parameter int WIDTH = WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/bitmap_free_extent_manager_core.sv
// Bitmap free extent manager: a block allocation bitmap with toggle, verify
// and free-extent enumeration, walked one bit per cycle by a sequencer that pauses to read each bitmap word.
// A walk reads each bitmap word it covers and steps through its blocks before its result is valid;
// malformed ranges, restarts and finished enumerations are answered at acceptance, without a walk.
// One transaction at a time; input stalls while walking or while a stalled result waits.
// After reset a clearing pass over all NWORDS bitmap words blocks input; config always.
module bitmap_free_extent_manager_core import bfem_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_func,
  input  logic [ADDR_BITS-1:0] in_byte_offset,
  input  logic [ADDR_BITS-1:0] in_byte_length,
  input  logic                 in_expect_set,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [ADDR_BITS-1:0] out_extent_offset,
  output logic [ADDR_BITS-1:0] out_extent_length,
  output logic [CNT_BITS-1:0]  out_mismatch_count,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  localparam int NWORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BA = $clog2(WORD_BITS);
  localparam int IB = $clog2(MAX_BLOCKS) + 1;  // block index incl. MAX_BLOCKS

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_WAIT  = 8'b0000_1000,
    S_BIT   = 8'b0001_0000,
    S_OUT   = 8'b0010_0000,
    S_CHECK = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [SHIFT_BITS-1:0] block_shift_r;
  logic [CNT_BITS-1:0]   total_blocks_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_shift_r  <= SHIFT_RST;
      total_blocks_r <= CNT_BITS'(MAX_BLOCKS_DEF);
    end else if (cfg_wr && cfg_paddr[2] == CFG_SHIFT && cfg_paddr[1:0] == 2'd0) begin
      block_shift_r <= cfg_pwdata[SHIFT_BITS-1:0];
    end else if (cfg_wr && cfg_paddr[2] == CFG_BLOCKS && cfg_paddr[1:0] == 2'd0) begin
      total_blocks_r <= cfg_pwdata[CNT_BITS-1:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == 3'd0) cfg_prdata = 32'(block_shift_r);
    else if (cfg_paddr == 3'd4) cfg_prdata = 32'(total_blocks_r);
  end

  // Effective shift and device size.
  logic [SHIFT_BITS-1:0] sh;
  logic [IB-1:0]         tb;
  always_comb begin
    if (block_shift_r < SHIFT_MIN) sh = SHIFT_MIN;
    else if (block_shift_r > SHIFT_MAX) sh = SHIFT_MAX;
    else sh = block_shift_r;
    if (32'(total_blocks_r) > 32'(MAX_BLOCKS)) tb = IB'(MAX_BLOCKS);
    else tb = IB'(total_blocks_r);
  end

  // Range check on the incoming request, done in the accept cycle.
  logic [ADDR_BITS-1:0] amask, sb_full, nb_full;
  logic bad_range;
  always_comb begin
    amask   = (ADDR_BITS'(1) << sh) - ADDR_BITS'(1);
    sb_full = in_byte_offset >> sh;
    nb_full = in_byte_length >> sh;
    bad_range = ((in_byte_offset & amask) != '0) || ((in_byte_length & amask) != '0) ||
                (nb_full == '0) || (sb_full >= ADDR_BITS'(tb)) ||
                (nb_full > (ADDR_BITS'(tb) - sb_full));
  end

  // Working registers.
  logic [1:0]          func_r;
  logic                expect_r;
  logic [IB-1:0]       idx_r, idx_nxt;     // current block
  logic [IB-1:0]       end_r;              // exclusive end of toggle/verify
  logic [IB-1:0]       run_start_r;
  logic                in_run_r;           // enumeration: a free run was found
  logic [CNT_BITS-1:0] cnt_r;
  logic [IB-1:0]       cursor_r;
  logic                finished_r;
  logic [WORD_BITS-1:0] word_r;            // current bitmap word; toggle modifies it

  // Result register.
  logic [1:0]           res_status_r;
  logic [ADDR_BITS-1:0] res_off_r, res_len_r;
  logic [CNT_BITS-1:0]  res_cnt_r;
  logic                 out_valid_r;

  // Memory.
  logic                 ram_we;
  logic [WA-1:0]        ram_waddr, ram_raddr, clr_r;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  bfem_bitmap_ram #(.DEPTH(NWORDS), .WIDTH(WORD_BITS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // A held result only blocks the input while it is itself stalled; otherwise it
  // leaves at the same edge the next transaction is taken.
  logic in_acc;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  logic [WA-1:0] widx;
  logic [BA-1:0] bidx;
  logic          cur_bit, last_in_word, at_end;
  assign widx = WA'(idx_r >> BA);
  assign bidx = idx_r[BA-1:0];
  assign cur_bit = (idx_r >= IB'(MAX_BLOCKS)) ? 1'b1 : word_r[bidx];
  assign last_in_word = (bidx == BA'(WORD_BITS - 1));
  assign ram_raddr = widx;

  // Toggle writes back the modified word when it leaves it.
  assign at_end = (func_r == FN_NEXT) ? (idx_r + IB'(1) >= tb) : (idx_r + IB'(1) >= end_r);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = widx;
    ram_wdata = word_r ^ (WORD_BITS'(1) << bidx);
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == S_BIT && func_r == FN_TOGGLE && (last_in_word || at_end)) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r + IB'(1);
    case (state_r)
      S_CLEAR: if (clr_r == WA'(NWORDS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        state_nxt = S_IDLE;
        if (in_acc) begin
          case (func_t'(in_func))
            FN_TOGGLE, FN_VERIFY: if (!bad_range) state_nxt = S_READ;
            FN_NEXT: if (!finished_r && cursor_r < tb) state_nxt = S_READ;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_BIT;
      S_BIT: begin
        if (func_r == FN_NEXT) begin
          if (in_run_r && cur_bit) state_nxt = S_OUT;
          else if (at_end) state_nxt = S_OUT;
          else if (last_in_word) state_nxt = S_READ;
        end else if (at_end) begin
          state_nxt = S_OUT;
        end else if (last_in_word) begin
          state_nxt = S_READ;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      S_CHECK: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cursor_r    <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall && !in_acc) out_valid_r <= 1'b0;
      if (state_r == S_CLEAR) clr_r <= clr_r + WA'(1);
      if (state_r == S_WAIT) word_r <= ram_rdata;
      if (in_acc) begin
        func_r   <= in_func;
        expect_r <= in_expect_set;
        cnt_r    <= '0;
        in_run_r <= 1'b0;
        res_off_r <= '0;
        res_len_r <= '0;
        res_cnt_r <= '0;
        case (func_t'(in_func))
          FN_TOGGLE, FN_VERIFY: begin
            if (bad_range) begin
              res_status_r <= ST_BAD;
              out_valid_r  <= 1'b1;
            end else begin
              idx_r       <= IB'(sb_full);
              end_r       <= IB'(sb_full) + IB'(nb_full);
              out_valid_r <= 1'b0;
            end
          end
          FN_RESTART: begin
            cursor_r     <= '0;
            finished_r   <= 1'b0;
            res_status_r <= ST_OK;
            out_valid_r  <= 1'b1;
          end
          default: begin
            if (finished_r || cursor_r >= tb) begin
              finished_r   <= 1'b1;
              res_status_r <= ST_FINISHED;
              out_valid_r  <= 1'b1;
            end else begin
              idx_r       <= cursor_r;
              out_valid_r <= 1'b0;
            end
          end
        endcase
      end
      if (state_r == S_BIT) begin
        idx_r <= idx_nxt;
        if (func_r == FN_TOGGLE) begin
          word_r[bidx] <= ~word_r[bidx];
        end else if (func_r == FN_VERIFY) begin
          if (cur_bit != expect_r) cnt_r <= cnt_r + CNT_BITS'(1);
        end else begin
          if (!in_run_r && !cur_bit) begin
            in_run_r    <= 1'b1;
            run_start_r <= idx_r;
          end
        end
      end
      if (state_r == S_BIT && state_nxt == S_OUT) begin
        out_valid_r <= 1'b1;
        if (func_r == FN_TOGGLE) begin
          res_status_r <= ST_OK;
        end else if (func_r == FN_VERIFY) begin
          res_cnt_r <= (cur_bit != expect_r) ? cnt_r + CNT_BITS'(1) : cnt_r;
          res_status_r <= ((cur_bit != expect_r) || cnt_r != '0) ? ST_MISMATCH : ST_OK;
        end else if (in_run_r && cur_bit) begin
          // Run ended at an allocated block.
          res_status_r <= ST_OK;
          res_off_r <= ADDR_BITS'(run_start_r) << sh;
          res_len_r <= ADDR_BITS'(idx_r - run_start_r) << sh;
          cursor_r  <= idx_r;
        end else if (in_run_r || !cur_bit) begin
          // Run reaches the device end.
          res_status_r <= ST_OK;
          res_off_r <= ADDR_BITS'(in_run_r ? run_start_r : idx_r) << sh;
          res_len_r <= ADDR_BITS'(tb - (in_run_r ? run_start_r : idx_r)) << sh;
          cursor_r  <= tb;
        end else begin
          res_status_r <= ST_FINISHED;
          finished_r   <= 1'b1;
          cursor_r     <= tb;
        end
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_status_r;
  assign out_extent_offset  = res_off_r;
  assign out_extent_length  = res_len_r;
  assign out_mismatch_count = res_cnt_r;

  // A pending result never coexists with active sequencing.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE || state_r == S_OUT))
    else $error("result pending while sequencer busy");
  // Memory is written only while clearing or walking a toggle.
  a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || (state_r == S_BIT && func_r == FN_TOGGLE)))
    else $error("unexpected bitmap write");
  // The enumeration cursor never passes MAX_BLOCKS.
  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == S_OUT) |-> (cursor_r <= IB'(MAX_BLOCKS)))
    else $error("cursor out of range");
endmodule
